@@ sv/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg
// Shared constants, codes, types and ring-pointer helpers for the
// double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int DEPTH = 64;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam int DATA_W = 32;

   // actions
   localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
   localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
   localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
   localparam logic [2:0] ACT_POP_BACK   = 3'd3;
   localparam logic [2:0] ACT_DUMP       = 3'd4;

   // result status
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // datapath operations
   localparam logic [2:0] OP_NONE         = 3'd0;
   localparam logic [2:0] OP_PUSH_FRONT   = 3'd1;
   localparam logic [2:0] OP_PUSH_BACK    = 3'd2;
   localparam logic [2:0] OP_POP_FRONT    = 3'd3;
   localparam logic [2:0] OP_POP_BACK     = 3'd4;
   localparam logic [2:0] OP_REPORT_FULL  = 3'd5;
   localparam logic [2:0] OP_REPORT_EMPTY = 3'd6;
   localparam logic [2:0] OP_DUMP_STEP    = 3'd7;

   typedef struct packed {
      logic       load;
      logic [2:0] op;
   } cmd_type;

   typedef struct packed {
      logic [2:0] action;
      logic       empty;
      logic       full;
      logic       dump_last;
   } sts_type;

   function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
      return (p == IDX_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] ptr_dec(input logic [IDX_W-1:0] p);
      return (p == '0) ? IDX_W'(DEPTH - 1) : p - 1'b1;
   endfunction

   // base + off modulo DEPTH, with base < DEPTH and off <= DEPTH
   function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(off);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return IDX_W'(sum);
   endfunction

endpackage

@@ sv/double_ended_queue.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed 32-bit words in a ring memory, with
// push and pop at either end and a dump of the whole contents.
// ----------------------------------------------------------------------------
// channel   ports                                        handshake
// request   req_action, req_value                        start high, busy low
// response  rsp_status, rsp_item, rsp_last               rsp_valid, one cycle
//
// push, pop, refused or undefined action: busy in the execute state after accept,
//   no new request until busy is low; the word is registered in that state
// dump of n entries: busy until the last of n steps is issued, one word per cycle
// reset clears pointer and count at once; no clearing pass of the memory
// the receiver cannot stall; an undefined action gives no word
// ----------------------------------------------------------------------------
module double_ended_queue import deq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [2:0]               req_action,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_status,
   output logic signed [DATA_W-1:0] rsp_item,
   output logic                     rsp_last
);

   cmd_type cmd;
   sts_type sts;

   deq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   deq_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_action (req_action),
      .req_value  (req_value),
      .sts        (sts),
      .rsp_valid  (rsp_valid),
      .rsp_status (rsp_status),
      .rsp_item   (rsp_item),
      .rsp_last   (rsp_last)
   );

endmodule

@@ sv/deq_ctrl.sv @@
// ----------------------------------------------------------------------------
// deq_ctrl
// Controller of the double-ended queue: accepts commands, picks the
// datapath operation and sequences dump runs.
// ----------------------------------------------------------------------------
module deq_ctrl import deq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    busy
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_DUMP = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd.load = 1'b0;
      cmd.op   = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
            unique case (sts.action) inside
               ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                  if (sts.full) begin
                     cmd.op = OP_REPORT_FULL;
                  end else if (sts.action == ACT_PUSH_FRONT) begin
                     cmd.op = OP_PUSH_FRONT;
                  end else begin
                     cmd.op = OP_PUSH_BACK;
                  end
               end
               ACT_POP_FRONT, ACT_POP_BACK: begin
                  if (sts.empty) begin
                     cmd.op = OP_REPORT_EMPTY;
                  end else if (sts.action == ACT_POP_FRONT) begin
                     cmd.op = OP_POP_FRONT;
                  end else begin
                     cmd.op = OP_POP_BACK;
                  end
               end
               ACT_DUMP: begin
                  if (sts.empty) begin
                     cmd.op = OP_REPORT_EMPTY;
                  end else begin
                     cmd.op = OP_DUMP_STEP;
                     if (!sts.dump_last) begin
                        state_in = S_DUMP;
                     end
                  end
               end
               default: begin
                  cmd.op = OP_NONE;
               end
            endcase
         end
         S_DUMP: begin
            cmd.op = OP_DUMP_STEP;
            if (sts.dump_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

@@ sv/deq_dp.sv @@
// ----------------------------------------------------------------------------
// deq_dp
// Datapath of the double-ended queue: ring memory, front pointer, count,
// dump walker and the registered result word.
// ----------------------------------------------------------------------------
module deq_dp import deq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   input  logic [2:0]               req_action,
   input  logic signed [DATA_W-1:0] req_value,
   output sts_type                  sts,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_status,
   output logic signed [DATA_W-1:0] rsp_item,
   output logic                     rsp_last
);

   logic [DATA_W-1:0] ring_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   logic [IDX_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [2:0]       act_ff, act_in;
   logic [DATA_W-1:0] value_ff, value_in;
   logic [IDX_W-1:0] dump_ptr_ff, dump_ptr_in;
   logic [CNT_W-1:0] dump_idx_ff, dump_idx_in;
   logic             valid_ff, valid_in;
   logic [1:0]       status_ff, status_in;
   logic             last_ff, last_in;
   logic             from_mem_ff, from_mem_in;

   logic             wr_en, rd_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;

   assign sts.action    = act_ff;
   assign sts.empty     = (count_ff == '0);
   assign sts.full      = (count_ff == CNT_W'(DEPTH));
   assign sts.dump_last = (dump_idx_ff == count_ff - 1'b1);

   always_comb begin
      front_in    = front_ff;
      count_in    = count_ff;
      act_in      = act_ff;
      value_in    = value_ff;
      dump_ptr_in = dump_ptr_ff;
      dump_idx_in = dump_idx_ff;
      valid_in    = 1'b0;
      status_in   = status_ff;
      last_in     = last_ff;
      from_mem_in = from_mem_ff;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      wr_addr     = front_ff;
      rd_addr     = front_ff;

      if (cmd.load) begin
         act_in      = req_action;
         value_in    = req_value;
         dump_ptr_in = front_ff;
         dump_idx_in = '0;
      end

      case (cmd.op)
         OP_PUSH_FRONT: begin
            front_in    = ptr_dec(front_ff);
            wr_addr     = ptr_dec(front_ff);
            wr_en       = 1'b1;
            count_in    = count_ff + 1'b1;
            valid_in    = 1'b1;
            status_in   = ST_OK;
            last_in     = 1'b1;
            from_mem_in = 1'b0;
         end
         OP_PUSH_BACK: begin
            wr_addr     = ring_add(front_ff, count_ff);
            wr_en       = 1'b1;
            count_in    = count_ff + 1'b1;
            valid_in    = 1'b1;
            status_in   = ST_OK;
            last_in     = 1'b1;
            from_mem_in = 1'b0;
         end
         OP_POP_FRONT: begin
            rd_addr     = front_ff;
            rd_en       = 1'b1;
            front_in    = ptr_inc(front_ff);
            count_in    = count_ff - 1'b1;
            valid_in    = 1'b1;
            status_in   = ST_OK;
            last_in     = 1'b1;
            from_mem_in = 1'b1;
         end
         OP_POP_BACK: begin
            rd_addr     = ring_add(front_ff, count_ff - 1'b1);
            rd_en       = 1'b1;
            count_in    = count_ff - 1'b1;
            valid_in    = 1'b1;
            status_in   = ST_OK;
            last_in     = 1'b1;
            from_mem_in = 1'b1;
         end
         OP_REPORT_FULL: begin
            valid_in    = 1'b1;
            status_in   = ST_FULL;
            last_in     = 1'b1;
            from_mem_in = 1'b0;
         end
         OP_REPORT_EMPTY: begin
            valid_in    = 1'b1;
            status_in   = ST_EMPTY;
            last_in     = 1'b1;
            from_mem_in = 1'b0;
         end
         OP_DUMP_STEP: begin
            rd_addr     = dump_ptr_ff;
            rd_en       = 1'b1;
            dump_ptr_in = ptr_inc(dump_ptr_ff);
            dump_idx_in = dump_idx_ff + 1'b1;
            valid_in    = 1'b1;
            status_in   = ST_OK;
            last_in     = sts.dump_last;
            from_mem_in = 1'b1;
         end
         default: begin
            valid_in = 1'b0;
         end
      endcase
   end

   // ring memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_ff[wr_addr] <= value_ff;
      end
      if (rd_en) begin
         rd_data_ff <= ring_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         front_ff <= front_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      value_ff    <= value_in;
      dump_ptr_ff <= dump_ptr_in;
      dump_idx_ff <= dump_idx_in;
      status_ff   <= status_in;
      last_ff     <= last_in;
      from_mem_ff <= from_mem_in;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_status = status_ff;
   assign rsp_last   = last_ff;
   assign rsp_item   = from_mem_ff ? $signed(rd_data_ff) : '0;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_PUSH_FRONT || cmd.op == OP_PUSH_BACK)
      |=> count_ff == $past(count_ff) + 1'b1)
      else $error("push did not add one entry");

   a_dump_keeps: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_DUMP_STEP |=> $stable(count_ff) && $stable(front_ff))
      else $error("dump changed the queue");

   a_refuse_keeps: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_REPORT_FULL || cmd.op == OP_REPORT_EMPTY)
      |=> $stable(count_ff) && rsp_valid && rsp_last)
      else $error("refused word changed state or was not sent");
`endif

endmodule

@@ tb/sv/double_ended_queue_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// Drives push, pop, dump and undefined actions into the double-ended queue,
// mirrors the ring contents to predict every word, and checks each word
// field by field as it leaves the block.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
   import deq_pkg::*;

   localparam logic [2:0] ACT_UNDEF_LO = 3'd5;
   localparam logic [2:0] ACT_UNDEF_HI = 3'd7;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [DATA_W-1:0] item;
      logic                     last;
   } deq_word_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [2:0]               req_action = '0;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic [1:0]               rsp_status;
   logic signed [DATA_W-1:0] rsp_item;
   logic                     rsp_last;

   logic signed [DATA_W-1:0] ring_mirror [DEPTH];
   int                       front_mirror = 0;
   int                       count_mirror = 0;
   deq_word_type             pending_words [$];
   int                       error_count = 0;
   int                       idle_pct = 0;

   always #5 clock = ~clock;

   double_ended_queue uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_action (req_action),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_status (rsp_status),
      .rsp_item   (rsp_item),
      .rsp_last   (rsp_last)
   );

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic void expect_word(input logic [1:0] status,
                                       input logic signed [DATA_W-1:0] item,
                                       input logic last);
      deq_word_type w;
      w.status = status;
      w.item = item;
      w.last = last;
      pending_words.push_back(w);
   endfunction

   function automatic void predict_deque_op(input logic [2:0] action,
                                            input logic signed [DATA_W-1:0] value);
      int pos;
      case (action)
         ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
            if (count_mirror >= DEPTH) begin
               expect_word(ST_FULL, '0, 1'b1);
            end else begin
               if (action == ACT_PUSH_FRONT) begin
                  front_mirror = (front_mirror + DEPTH - 1) % DEPTH;
                  ring_mirror[front_mirror] = value;
               end else begin
                  ring_mirror[(front_mirror + count_mirror) % DEPTH] = value;
               end
               count_mirror++;
               expect_word(ST_OK, '0, 1'b1);
            end
         end
         ACT_POP_FRONT, ACT_POP_BACK: begin
            if (count_mirror == 0) begin
               expect_word(ST_EMPTY, '0, 1'b1);
            end else begin
               if (action == ACT_POP_FRONT) begin
                  pos = front_mirror;
                  front_mirror = (front_mirror + 1) % DEPTH;
               end else begin
                  pos = (front_mirror + count_mirror - 1) % DEPTH;
               end
               count_mirror--;
               expect_word(ST_OK, ring_mirror[pos], 1'b1);
            end
         end
         ACT_DUMP: begin
            if (count_mirror == 0) begin
               expect_word(ST_EMPTY, '0, 1'b1);
            end else begin
               for (int i = 0; i < count_mirror; i++) begin
                  expect_word(ST_OK, ring_mirror[(front_mirror + i) % DEPTH],
                              i == count_mirror - 1);
               end
            end
         end
         default: ;
      endcase
   endfunction

   task automatic send_word(input logic [2:0] action,
                            input logic signed [DATA_W-1:0] value);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start <= 1'b1;
      req_action <= action;
      req_value <= value;
      do @(posedge clock); while (busy);
      predict_deque_op(action, value);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin : word_check
      deq_word_type want;
      if (!reset && rsp_valid) begin
         if (pending_words.size() == 0) begin
            report_mismatch("word with none expected");
         end else begin
            want = pending_words.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_status, want.status));
            if (rsp_item !== want.item)
               report_mismatch($sformatf("item %0d, expected %0d",
                                         rsp_item, want.item));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last %0b, expected %0b",
                                         rsp_last, want.last));
         end
      end
   end

   task automatic test_empty_deque();
      send_word(ACT_POP_FRONT, $urandom);
      send_word(ACT_POP_BACK, $urandom);
      send_word(ACT_DUMP, $urandom);
      for (int a = ACT_UNDEF_LO; a <= ACT_UNDEF_HI; a++) begin
         send_word(3'(a), $urandom);
      end
   endtask

   task automatic test_value_extremes();
      send_word(ACT_PUSH_FRONT, 32'sh7fff_ffff);
      send_word(ACT_PUSH_BACK, 32'sh8000_0000);
      send_word(ACT_PUSH_FRONT, -32'sd1);
      send_word(ACT_PUSH_BACK, 32'sd0);
      send_word(ACT_PUSH_BACK, 32'sh5555_5555);
      send_word(ACT_PUSH_FRONT, 32'shaaaa_aaaa);
      send_word(ACT_DUMP, $urandom);
      send_word(ACT_POP_FRONT, $urandom);
      send_word(ACT_POP_BACK, $urandom);
      send_word(ACT_POP_FRONT, $urandom);
      send_word(ACT_POP_BACK, $urandom);
      send_word(ACT_POP_FRONT, $urandom);
      send_word(ACT_POP_BACK, $urandom);
      send_word(ACT_POP_BACK, $urandom);
   endtask

   task automatic test_full_wrap();
      repeat (5) send_word(ACT_PUSH_FRONT, $urandom);
      while (count_mirror < DEPTH) send_word(ACT_PUSH_BACK, $urandom);
      send_word(ACT_PUSH_FRONT, $urandom);
      send_word(ACT_PUSH_BACK, $urandom);
      send_word(ACT_DUMP, $urandom);
      while (count_mirror > DEPTH - 12) begin
         send_word(($urandom_range(1) != 0) ? ACT_POP_FRONT : ACT_POP_BACK, $urandom);
      end
   endtask

   task automatic test_random(input int words, input int idle, input int push_pct);
      int done;
      int pick;
      logic [2:0] act;
      done = 0;
      idle_pct = idle;
      while (done < words) begin
         if ($urandom_range(99) < 5) begin
            send_word(3'($urandom_range(ACT_UNDEF_HI, ACT_UNDEF_LO)), $urandom);
         end else begin
            pick = $urandom_range(99);
            if (pick < push_pct) begin
               act = ($urandom_range(1) != 0) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
            end else if (pick < push_pct + 12) begin
               act = ACT_DUMP;
            end else begin
               act = ($urandom_range(1) != 0) ? ACT_POP_FRONT : ACT_POP_BACK;
            end
            send_word(act, $urandom);
            done++;
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      idle_pct = 9;
      test_empty_deque();
      wait_drained();
      test_value_extremes();
      wait_drained();
      test_full_wrap();
      wait_drained();
      test_random(5, 9, 55);
      wait_drained();
      test_random(5, 67, 40);
      wait_drained();
      test_random(5, 0, 30);
      wait_drained();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

@@ double_ended_queue.f @@
sv/deq_pkg.sv
sv/deq_ctrl.sv
sv/deq_dp.sv
sv/double_ended_queue.sv
tb/sv/double_ended_queue_tb.sv
